/* rtl/core/sbst_pkg.sv */
// shared types, constants and helpers for the software breakpoint slot table
package sbst_pkg;

    localparam int SLOTS         = 8;
    localparam int SLOT_IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W        = 32;
    localparam int WORD_W        = 16;
    localparam int TYPE_W        = 3;
    localparam int STATUS_W      = 3;
    localparam int SLOT_FIELD_W  = 3;

    localparam logic [7:0]        TRAP_RESET_HI = 8'h4A;
    localparam logic [7:0]        TRAP_RESET_LO = 8'hFC;
    localparam logic [WORD_W-1:0] TRAP_RESET    = {TRAP_RESET_HI, TRAP_RESET_LO};
    localparam logic [ADDR_W-1:0] FREE_ADDR     = 32'h0000_0000;

    localparam logic              KIND_INSERT = 1'b0;
    localparam logic              KIND_DELETE = 1'b1;
    localparam logic [TYPE_W-1:0] BP_TYPE_SW  = 3'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_TYPE    = 3'd1,
        ST_ALREADY_SET = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_FOUND   = 3'd4
    } status_t;

    typedef logic [SLOTS-1:0][ADDR_W-1:0] addr_array_t;
    typedef logic [SLOT_IDX_W-1:0]        slot_idx_t;

    // lookup results from the comparator bank
    typedef struct packed {
        logic      match_hit;
        slot_idx_t match_idx;
        logic      free_hit;
        slot_idx_t free_idx;
    } slot_lookup_t;

    // table update for one request
    typedef struct packed {
        logic              ins;
        logic              del;
        slot_idx_t         idx;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] word;
    } slot_upd_t;

    // lowest set bit of a slot mask
    function automatic slot_idx_t first_set(input logic [SLOTS-1:0] mask);
        slot_idx_t idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = SLOT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/software_breakpoint_slot_table_unit.sv */
// top level of the software breakpoint slot table
// usage:
//   requests enter on the s_ stream channel, one transfer per request:
//   s_tuser carries kind and breakpoint type, s_tdata the target address
//   and the original instruction word. every request yields exactly one
//   result transfer on the m_ channel with a status, a memory write
//   request (address and word) and the slot index used.
//   the trap word register is written over the cfg_ channel, which is
//   always ready; write it only while no request is in flight.
// pipeline and throughput:
//   a request is captured in the input register at its s_ transfer and
//   resolved by the comparator bank into the result register (m_tvalid).
//   while m_tready is high one request per cycle is sustained, since the
//   slot table updates at the edge that loads the result.
// reset:
//   aresetn low frees all slots, clears saved words, loads the default
//   trap word and empties both pipeline registers.
// stalls:
//   when m_tready is low the result holds and the input register holds
//   one more request; s_tready drops only when both are occupied.
module software_breakpoint_slot_table_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address[31:0], original_word[47:32]
    input  logic [3:0]  s_tuser,   // kind[0], bp_type[3:1]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], mem_write[3], write_address[35:4],
                                   // write_word[51:36], slot[54:52], zero[55]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // trap_word[15:0]
);

    // trap word register
    logic [sbst_pkg::WORD_W-1:0] trap_word_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trap_word_reg <= sbst_pkg::TRAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            trap_word_reg <= cfg_data;
        end
    end

    // input register
    logic                          in_valid_reg;
    logic                          in_kind_reg;
    logic [sbst_pkg::TYPE_W-1:0]   in_type_reg;
    logic [sbst_pkg::ADDR_W-1:0]   in_addr_reg;
    logic [sbst_pkg::WORD_W-1:0]   in_word_reg;

    // result register
    logic                          out_valid_reg;
    sbst_pkg::status_t             status_reg,   status_next;
    logic                          mem_write_reg, mem_write_next;
    logic [sbst_pkg::ADDR_W-1:0]   waddr_reg,    waddr_next;
    logic [sbst_pkg::WORD_W-1:0]   wword_reg,    wword_next;
    logic [sbst_pkg::SLOT_FIELD_W-1:0] slot_reg, slot_next;

    // the request in the input register moves on when the result slot frees
    logic advance;
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser[0];
            in_type_reg <= s_tuser[3:1];
            in_addr_reg <= s_tdata[31:0];
            in_word_reg <= s_tdata[47:32];
        end
    end

    // slot table and lookup
    sbst_pkg::addr_array_t         slot_address;
    sbst_pkg::slot_lookup_t        lookup;
    sbst_pkg::slot_upd_t           upd;
    logic [sbst_pkg::WORD_W-1:0]   saved_word;

    sbst_match u_match (
        .slot_address (slot_address),
        .req_address  (in_addr_reg),
        .lookup       (lookup)
    );

    sbst_slot_store u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd          (upd),
        .rd_idx       (lookup.match_idx),
        .slot_address (slot_address),
        .rd_word      (saved_word)
    );

    // request decode; failed requests leave the table unchanged and the write fields at zero
    logic fire;
    assign fire = in_valid_reg && advance;

    always_comb begin
        status_next    = sbst_pkg::ST_OK;
        mem_write_next = 1'b0;
        waddr_next     = '0;
        wword_next     = '0;
        slot_next      = '0;
        upd.ins        = 1'b0;
        upd.del        = 1'b0;
        upd.idx        = lookup.free_idx;
        upd.address    = in_addr_reg;
        upd.word       = in_word_reg;
        if (in_type_reg != sbst_pkg::BP_TYPE_SW) begin
            status_next = sbst_pkg::ST_BAD_TYPE;
        end else if (in_kind_reg == sbst_pkg::KIND_INSERT) begin
            // address zero matches any free slot, so it reports already set, or full when no slot is free
            if (lookup.match_hit) begin
                status_next = sbst_pkg::ST_ALREADY_SET;
            end else if (!lookup.free_hit) begin
                status_next = sbst_pkg::ST_FULL;
            end else begin
                mem_write_next = 1'b1;
                waddr_next     = in_addr_reg;
                wword_next     = trap_word_reg;
                slot_next      = sbst_pkg::SLOT_FIELD_W'(lookup.free_idx);
                upd.ins        = fire;
            end
        end else begin
            if (!lookup.match_hit) begin
                status_next = sbst_pkg::ST_NOT_FOUND;
            end else begin
                mem_write_next = 1'b1;
                waddr_next     = in_addr_reg;
                wword_next     = saved_word;
                slot_next      = sbst_pkg::SLOT_FIELD_W'(lookup.match_idx);
                upd.idx        = lookup.match_idx;
                upd.del        = fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg    <= status_next;
            mem_write_reg <= mem_write_next;
            waddr_reg     <= waddr_next;
            wword_reg     <= wword_next;
            slot_reg      <= slot_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, slot_reg, wword_reg, waddr_reg, mem_write_reg, status_reg};

    // a successful result always carries a memory write, a failed one nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (mem_write_reg == (status_reg == sbst_pkg::ST_OK)))
        else $error("memory write does not follow status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg != sbst_pkg::ST_OK) |->
            (waddr_reg == '0 && wword_reg == '0 && slot_reg == '0))
        else $error("failed result carries write fields");

    // the table only changes when a request leaves the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |-> (!upd.ins && !upd.del))
        else $error("table update without a request");

    // an insert result never names address zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && upd.ins) |-> (in_addr_reg != sbst_pkg::FREE_ADDR))
        else $error("insert of address zero");

endmodule

/* rtl/core/sbst_match.sv */
// parallel address comparators and priority encoders over the slot table
module sbst_match (
    input  sbst_pkg::addr_array_t              slot_address,
    input  logic [sbst_pkg::ADDR_W-1:0]        req_address,
    output sbst_pkg::slot_lookup_t             lookup
);

    logic [sbst_pkg::SLOTS-1:0] match_mask;
    logic [sbst_pkg::SLOTS-1:0] free_mask;

    always_comb begin
        for (int i = 0; i < sbst_pkg::SLOTS; i++) begin
            match_mask[i] = (slot_address[i] == req_address);
            free_mask[i]  = (slot_address[i] == sbst_pkg::FREE_ADDR);
        end
    end

    always_comb begin
        lookup.match_hit = |match_mask;
        lookup.match_idx = sbst_pkg::first_set(match_mask);
        lookup.free_hit  = |free_mask;
        lookup.free_idx  = sbst_pkg::first_set(free_mask);
    end

endmodule

/* rtl/core/sbst_slot_store.sv */
// slot registers: breakpoint addresses and saved instruction words
module sbst_slot_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbst_pkg::slot_upd_t           upd,
    input  sbst_pkg::slot_idx_t           rd_idx,
    output sbst_pkg::addr_array_t         slot_address,
    output logic [sbst_pkg::WORD_W-1:0]   rd_word
);

    sbst_pkg::addr_array_t                               slot_address_reg;
    logic [sbst_pkg::SLOTS-1:0][sbst_pkg::WORD_W-1:0]    slot_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_address_reg <= '0;
            slot_word_reg    <= '0;
        end else if (upd.ins) begin
            slot_address_reg[upd.idx] <= upd.address;
            slot_word_reg[upd.idx]    <= upd.word;
        end else if (upd.del) begin
            // freeing keeps the saved word
            slot_address_reg[upd.idx] <= sbst_pkg::FREE_ADDR;
        end
    end

    assign slot_address = slot_address_reg;
    assign rd_word      = slot_word_reg[rd_idx];

    assert property (@(posedge aclk) disable iff (!aresetn)
        upd.ins |=> slot_address_reg[$past(upd.idx)] == $past(upd.address))
        else $error("insert did not land in its slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        upd.del |=> slot_address_reg[$past(upd.idx)] == sbst_pkg::FREE_ADDR)
        else $error("delete did not free its slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        upd.del |=> slot_word_reg[$past(upd.idx)] == $past(slot_word_reg[upd.idx]))
        else $error("delete disturbed the saved word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(upd.ins && upd.del))
        else $error("insert and delete in one cycle");

endmodule
